FILE: hdl/cgc_pkg.sv
// ----------------------------------------------------------------------------
// cgc_pkg: shared types and constants of the coverage gap checker
// Bitmap geometry, field widths, item modes and register indexes.
// ----------------------------------------------------------------------------
package cgc_pkg;

    // Bitmap capacity in bases and its word organization
    localparam int MAX_LENGTH = 65536;
    localparam int WORD_W     = 32;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int NUM_WORDS  = MAX_LENGTH / WORD_W;
    localparam int ADDR_W     = $clog2(NUM_WORDS);

    // Field widths
    localparam int MODE_W     = 2;
    localparam int POS_W      = $clog2(MAX_LENGTH);
    localparam int LEN_W      = POS_W + 1;
    localparam int GAP_W      = 16;
    localparam int FRAC_W     = 16;
    localparam int FRACT_REG_W = FRAC_W + 1;
    localparam int PROD_W     = FRACT_REG_W + LEN_W;

    // Configuration port
    localparam int REG_IDX_W  = 1;
    localparam int CFG_DATA_W = FRACT_REG_W;

    localparam logic [GAP_W-1:0]       MAX_GAP_RESET      = GAP_W'(50);
    localparam logic [FRACT_REG_W-1:0] MIN_FRACTION_RESET = FRACT_REG_W'(58982);

    typedef enum logic [MODE_W-1:0] {
        MODE_START = 2'd0,
        MODE_HIT   = 2'd1,
        MODE_EVAL  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MAX_GAP      = 1'b0,
        REG_MIN_FRACTION = 1'b1
    } t_reg_idx;

endpackage

FILE: hdl/cgc_ifs.sv
// ----------------------------------------------------------------------------
// cgc_ifs: channel interfaces of the coverage gap checker
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface cgc_in_if;
    logic                           valid;
    logic                           ready;
    logic [cgc_pkg::MODE_W-1:0]     mode;
    logic [cgc_pkg::LEN_W-1:0]      ref_length;
    logic [cgc_pkg::POS_W-1:0]      start_pos;
    logic [cgc_pkg::LEN_W-1:0]      end_pos;

    modport source (output valid, mode, ref_length, start_pos, end_pos, input ready);
    modport sink   (input valid, mode, ref_length, start_pos, end_pos, output ready);
endinterface

interface cgc_out_if;
    logic                           valid;
    logic                           ready;
    logic                           expressed;
    logic                           gap_found;
    logic [cgc_pkg::LEN_W-1:0]      covered_count;

    modport source (output valid, expressed, gap_found, covered_count, input ready);
    modport sink   (input valid, expressed, gap_found, covered_count, output ready);
endinterface

interface cgc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [cgc_pkg::REG_IDX_W-1:0]      index;
    logic [cgc_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/coverage_gap_checker.sv
// ----------------------------------------------------------------------------
// coverage_gap_checker: coverage bitmap with gap and expression check
// Marks hit intervals of one reference, then scans for internal gaps.
// ----------------------------------------------------------------------------
// The block keeps a 65536-base coverage bitmap in a 2048 x 32-bit memory and
// serves one item at a time; i_in.ready is high only while it is idle. A
// start item saturates the length to 65536 and clears the bitmap with one
// word write per cycle; the same clearing pass runs after reset, and no item
// is taken until it ends (configuration writes always are). A hit item reads,
// then merges and writes, each 32-bit word the interval touches; an empty or
// reversed hit is taken without touching the bitmap. An evaluate item walks
// the bitmap one base per cycle, with a read step before each word, ending
// early at the first flagged gap; then a 17 x 17 multiply and a compare
// decide the expressed flag. The result waits in an output register; the
// block goes on taking start and hit items meanwhile. A further evaluate is
// taken and scanned, then holds in its compare step, with the input not
// ready, until the earlier result transfer has happened. Mode 3 items are
// dropped.
// ----------------------------------------------------------------------------
module coverage_gap_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cgc_in_if.sink      i_in,
    cgc_out_if.source   o_out,
    cgc_cfg_if.sink     i_cfg
);
    import cgc_pkg::*;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_HIT_RD,
        S_HIT_WR,
        S_EV_RD,
        S_EV_BIT,
        S_EV_MUL,
        S_EV_CMP
    } t_state;

    t_state                 r_state;

    // configuration
    logic [GAP_W-1:0]       r_max_gap;
    logic [FRACT_REG_W-1:0] r_min_fraction;

    // reference state
    logic [LEN_W-1:0]       r_len;

    // hit marking
    logic [ADDR_W-1:0]      r_word;
    logic [ADDR_W-1:0]      r_last_word;
    logic [BIT_W-1:0]       r_lo_bit;
    logic [BIT_W-1:0]       r_hi_bit;

    // scan
    logic [LEN_W-1:0]       r_idx;
    logic [LEN_W-1:0]       r_covered;
    logic [POS_W-1:0]       r_gap_start;
    logic                   r_prev;
    logic                   r_have_start;
    logic                   r_gap;
    logic [PROD_W-1:0]      r_prod;

    // result register
    logic                   r_out_valid;
    logic                   r_out_expressed;
    logic                   r_out_gap;
    logic [LEN_W-1:0]       r_out_covered;

    // memory port
    logic                   mem_wr_en;
    logic [ADDR_W-1:0]      mem_rd_addr;
    logic [WORD_W-1:0]      mem_wr_data;
    logic [WORD_W-1:0]      mem_rd_data;

    logic                   in_xfer;
    logic                   out_xfer;
    logic                   out_free;
    logic [LEN_W-1:0]       len_sat;
    logic [LEN_W-1:0]       hit_end;
    logic [LEN_W-1:0]       hit_last;
    logic                   hit_empty;
    logic [BIT_W-1:0]       mask_lo;
    logic [BIT_W-1:0]       mask_hi;
    logic [WORD_W-1:0]      hit_mask;
    logic                   cur_bit;
    logic [LEN_W-1:0]       idx_inc;
    logic [POS_W-1:0]       gap_dist;
    logic                   scan_done;

    cgc_bitmap u_bitmap (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_word),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // Handshakes: configuration is always taken, items only when idle
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in.valid && i_in.ready;
    assign out_xfer    = r_out_valid && o_out.ready;
    assign out_free    = !r_out_valid || o_out.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.expressed     = r_out_expressed;
    assign o_out.gap_found     = r_out_gap;
    assign o_out.covered_count = r_out_covered;

    // Start item: saturate the length to the bitmap capacity
    assign len_sat = (i_in.ref_length > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH)
                                                            : i_in.ref_length;

    // Hit item: clamp the end to the current length, find the last base
    assign hit_end   = (i_in.end_pos > r_len) ? r_len : i_in.end_pos;
    assign hit_empty = (hit_end <= {1'b0, i_in.start_pos});
    assign hit_last  = hit_end - LEN_W'(1);

    // Merge mask for the current word: partial at the first and last word
    assign mask_lo  = r_lo_bit;
    assign mask_hi  = (r_word == r_last_word) ? r_hi_bit : BIT_W'(WORD_W - 1);
    assign hit_mask = ({WORD_W{1'b1}} << mask_lo)
                    & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - mask_hi));

    // Memory port: clear pass writes zeros, hits merge the mask
    assign mem_wr_en   = (r_state == S_CLR) || (r_state == S_HIT_WR);
    assign mem_wr_data = (r_state == S_CLR) ? '0 : (mem_rd_data | hit_mask);
    assign mem_rd_addr = (r_state == S_EV_RD || r_state == S_EV_BIT)
                       ? r_idx[POS_W-1:BIT_W] : r_word;

    // Scan step on one base
    assign cur_bit   = mem_rd_data[r_idx[BIT_W-1:0]];
    assign idx_inc   = r_idx + LEN_W'(1);
    assign gap_dist  = r_idx[POS_W-1:0] - r_gap_start;
    assign scan_done = (idx_inc == r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLR;
            r_word         <= '0;
            r_len          <= '0;
            r_out_valid    <= 1'b0;
            r_max_gap      <= MAX_GAP_RESET;
            r_min_fraction <= MIN_FRACTION_RESET;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (t_reg_idx'(i_cfg.index))
                    REG_MAX_GAP:      r_max_gap      <= i_cfg.data[GAP_W-1:0];
                    REG_MIN_FRACTION: r_min_fraction <= i_cfg.data;
                    default:          ;
                endcase
            end

            if (out_xfer) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLR: begin
                    // sweep the bitmap, one word per cycle
                    r_word <= r_word + ADDR_W'(1);
                    if (r_word == ADDR_W'(NUM_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (in_xfer) begin
                        unique case (t_mode'(i_in.mode))
                            MODE_START: begin
                                r_len   <= len_sat;
                                r_word  <= '0;
                                r_state <= S_CLR;
                            end
                            MODE_HIT: begin
                                r_word      <= i_in.start_pos[POS_W-1:BIT_W];
                                r_lo_bit    <= i_in.start_pos[BIT_W-1:0];
                                r_last_word <= hit_last[POS_W-1:BIT_W];
                                r_hi_bit    <= hit_last[BIT_W-1:0];
                                if (!hit_empty) begin
                                    r_state <= S_HIT_RD;
                                end
                            end
                            MODE_EVAL: begin
                                r_idx        <= '0;
                                r_covered    <= '0;
                                r_gap_start  <= '0;
                                r_prev       <= 1'b0;
                                r_have_start <= 1'b0;
                                r_gap        <= 1'b0;
                                r_state      <= (r_len == '0) ? S_EV_MUL : S_EV_RD;
                            end
                            MODE_NONE: ;  // drop
                            default:   ;
                        endcase
                    end
                end

                S_HIT_RD: begin
                    r_state <= S_HIT_WR;
                end

                S_HIT_WR: begin
                    // advance to the next word, or finish at the last one
                    if (r_word == r_last_word) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_word   <= r_word + ADDR_W'(1);
                        r_lo_bit <= '0;
                        r_state  <= S_HIT_RD;
                    end
                end

                S_EV_RD: begin
                    r_state <= S_EV_BIT;
                end

                S_EV_BIT: begin
                    if (cur_bit) begin
                        r_covered <= r_covered + LEN_W'(1);
                        r_prev    <= 1'b1;
                    end else if (r_prev) begin
                        r_have_start <= 1'b1;
                        r_gap_start  <= r_idx[POS_W-1:0];
                        r_prev       <= 1'b0;
                    end else if (r_have_start && (gap_dist > r_max_gap)) begin
                        r_gap <= 1'b1;
                    end
                    r_idx <= idx_inc;
                    if (scan_done
                        || (!cur_bit && !r_prev && r_have_start
                            && (gap_dist > r_max_gap))) begin
                        r_state <= S_EV_MUL;
                    end else if (idx_inc[BIT_W-1:0] == '0) begin
                        r_state <= S_EV_RD;
                    end
                end

                S_EV_MUL: begin
                    r_prod  <= PROD_W'(r_min_fraction) * PROD_W'(r_len);
                    r_state <= S_EV_CMP;
                end

                S_EV_CMP: begin
                    // hold until the result register is free
                    if (out_free) begin
                        r_out_valid     <= 1'b1;
                        r_out_gap       <= r_gap;
                        r_out_covered   <= r_covered;
                        r_out_expressed <= !r_gap
                            && ({1'b0, r_covered, FRAC_W'(0)} > r_prod);
                        r_state         <= S_IDLE;
                    end
                end

                default: r_state <= S_CLR;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_LENGTH))
        else $error("reference length above capacity");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_in.mode == MODE_START)) |=> (r_state == S_CLR) && (r_word == '0))
        else $error("start item did not begin the clearing pass");

    a_covered_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EV_BIT) |-> (r_covered <= r_idx) && (r_idx < r_len))
        else $error("scan counters out of range");

    a_gap_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EV_MUL) && r_gap) |-> r_have_start)
        else $error("gap flagged without a recorded gap start");

    a_hit_word_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HIT_WR) |-> (r_word <= r_last_word))
        else $error("hit marking ran past its last word");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EV_CMP) && !out_free) |=> (r_state == S_EV_CMP))
        else $error("result dropped while the output register was full");

endmodule

FILE: hdl/cgc_bitmap.sv
// ----------------------------------------------------------------------------
// cgc_bitmap: word-wide coverage bitmap memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cgc_bitmap (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [cgc_pkg::ADDR_W-1:0]  i_wr_addr,
    input  logic [cgc_pkg::WORD_W-1:0]  i_wr_data,
    input  logic [cgc_pkg::ADDR_W-1:0]  i_rd_addr,
    output logic [cgc_pkg::WORD_W-1:0]  o_rd_data
);
    import cgc_pkg::*;

    logic [WORD_W-1:0] r_mem [NUM_WORDS];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
